// ===== rtl/brt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brt_pkg: shared types, constants and arithmetic for the beacon RSSI tracker
// Holds the item format, register indexes, filter constants and the
// rounding helpers used by the lanes and the output encoder.
// ----------------------------------------------------------------------------
package brt_pkg;

    localparam int NUM_BEACONS = 3;
    // Beacons that have an address register and a level output.
    localparam int ADDR_REGS   = 3;
    localparam int OUT_LEVELS  = 3;

    localparam int ADDR_W     = 48;
    localparam int TIMEOUT_W  = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_ADDRESS_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_ADDRESS_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_ADDRESS_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_TIMEOUT    = 3'd3;

    // Item kinds.
    localparam logic KIND_ADVERT = 1'b0;
    localparam logic KIND_SWEEP  = 1'b1;

    // Levels are signed Q8.8.
    localparam logic signed [15:0] LEVEL_RESET      = -16'sd25600;
    localparam logic signed [15:0] LEVEL_DIRECT_MAX = -16'sd25344;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd6000;

    // Blend weights: 102/256 for the new sample (pre-scaled by 256), 154/256 for the old level.
    localparam logic signed [23:0] WEIGHT_NEW_Q88 = 24'sd26112;
    localparam logic signed [23:0] WEIGHT_OLD     = 24'sd154;

    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  device_address;
        logic signed [7:0]  signal_dbm;
        logic [TIME_W-1:0]  now_ms;
    } brt_item_t;

    // Divide by 256, rounding to nearest with halves away from zero.
    function automatic logic signed [16:0] brt_round256(input logic signed [23:0] s);
        logic [23:0] s_bits;
        logic [23:0] mag;
        logic [16:0] q;
        s_bits = s;
        mag    = s_bits[23] ? (~s_bits + 24'd1) : s_bits;
        q      = 17'((mag + 24'd128) >> 8);
        return s_bits[23] ? (~q + 17'd1) : q;
    endfunction

    // Whole-dBm level from Q8.8, saturated to the 8-bit output range.
    function automatic logic [7:0] brt_encode(input logic signed [15:0] lvl);
        logic signed [16:0] r;
        r = brt_round256({{8{lvl[15]}}, lvl});
        if (r > 17'sd127)
            return 8'h7F;
        else if (r < -17'sd128)
            return 8'h80;
        else
            return r[7:0];
    endfunction

endpackage

// ===== rtl/beacon_rssi_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_rssi_tracker: smoothed RSSI tracking for configured beacons
// Input register, per-beacon update lanes and a result register.
// ----------------------------------------------------------------------------
// Usage:
//   Items (advertisement reports or staleness sweeps) arrive on the
//   in_valid/in_ready channel; one result per item leaves on the
//   out_valid/out_ready channel carrying the three rounded levels and the
//   match mask. Beacon addresses and the stale timeout are written on the
//   cfg_write/cfg_index/cfg_data port while no item is in flight.
//   An item is held in the input register, where the lanes update the
//   beacon state as it moves on, and its result is loaded into the output
//   register, which raises out_valid until the result transfers.
//   One item can be taken every cycle while the receiver does not stall;
//   the lanes update the state as each item leaves the input register.
//   If the receiver stalls, the result is held and one further item waits
//   in the input register; in_ready falls only while both are occupied.
//   Reset empties both registers, sets every level to -100 dBm, every last
//   seen time to zero, the addresses to zero and the timeout to 6000 ms.
// ----------------------------------------------------------------------------
module beacon_rssi_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [brt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [brt_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [brt_pkg::ADDR_W-1:0]    device_address,
    input  logic signed [7:0]             signal_dbm,
    input  logic [brt_pkg::TIME_W-1:0]    now_ms,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [7:0]             level_0,
    output logic signed [7:0]             level_1,
    output logic signed [7:0]             level_2,
    output logic [2:0]                    match_mask
);
    import brt_pkg::*;

    logic [ADDR_W-1:0]    addr_reg [ADDR_REGS];
    logic [TIMEOUT_W-1:0] timeout_reg;

    brt_item_t            item_reg;
    logic                 item_valid_reg;
    logic                 out_valid_reg;
    logic [7:0]           level_reg [OUT_LEVELS];
    logic [2:0]           mask_reg;

    logic                 advance;
    logic signed [15:0]   lane_level [NUM_BEACONS];
    logic [NUM_BEACONS-1:0] lane_match;
    logic [7:0]           level_next [OUT_LEVELS];
    logic [2:0]           mask_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ADDR_REGS; i++)
            begin
                addr_reg[i] <= '0;
            end
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BEACON_ADDRESS_0:
                begin
                    if (NUM_BEACONS > 0)
                        addr_reg[0] <= cfg_data;
                end
                CFG_BEACON_ADDRESS_1:
                begin
                    if (NUM_BEACONS > 1)
                        addr_reg[1] <= cfg_data;
                end
                CFG_BEACON_ADDRESS_2:
                begin
                    if (NUM_BEACONS > 2)
                        addr_reg[2] <= cfg_data;
                end
                CFG_STALE_TIMEOUT:
                begin
                    timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The held item moves on when the result register is free or being emptied.
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.kind           <= kind;
            item_reg.device_address <= device_address;
            item_reg.signal_dbm     <= signal_dbm;
            item_reg.now_ms         <= now_ms;
        end
    end

    for (genvar g = 0; g < NUM_BEACONS; g++)
    begin : g_lane
        logic [ADDR_W-1:0] lane_address;

        if (g < ADDR_REGS)
        begin : g_cfg
            assign lane_address = addr_reg[g];
        end
        else
        begin : g_zero
            assign lane_address = '0;
        end

        brt_lane u_lane (
            .clk              (clk),
            .rst_n            (rst_n),
            .beacon_address   (lane_address),
            .stale_timeout_ms (timeout_reg),
            .update           (advance),
            .item             (item_reg),
            .level_next       (lane_level[g]),
            .matched          (lane_match[g])
        );
    end

    for (genvar g = 0; g < OUT_LEVELS; g++)
    begin : g_out
        if (g < NUM_BEACONS)
        begin : g_used
            assign level_next[g] = brt_encode(lane_level[g]);
            assign mask_next[g]  = lane_match[g];
        end
        else
        begin : g_unused
            assign level_next[g] = brt_encode(LEVEL_RESET);
            assign mask_next[g]  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < OUT_LEVELS; i++)
            begin
                level_reg[i] <= level_next[i];
            end
            mask_reg <= mask_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign level_0    = level_reg[0];
    assign level_1    = level_reg[1];
    assign level_2    = level_reg[2];
    assign match_mask = mask_reg;

endmodule

// ===== rtl/brt_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brt_lane: tracking state and update logic for one beacon
// Compares the item address, ages the entry and blends the new RSSI into
// the level (taken as is at -99 dBm or below); the state is written on update.
// ----------------------------------------------------------------------------
module brt_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [brt_pkg::ADDR_W-1:0]    beacon_address,
    input  logic [brt_pkg::TIMEOUT_W-1:0] stale_timeout_ms,
    input  logic                         update,
    input  brt_pkg::brt_item_t           item,
    output logic signed [15:0]           level_next,
    output logic                         matched
);
    import brt_pkg::*;

    logic signed [15:0] level_reg;
    logic [TIME_W-1:0]  seen_reg;
    logic [TIME_W-1:0]  seen_next;

    logic               hit;
    logic               stale;
    logic               direct;
    logic [TIME_W-1:0]  age;
    logic signed [23:0] rssi_ext;
    logic signed [23:0] level_ext;
    logic signed [23:0] blend_sum;
    logic signed [16:0] blend_round;
    logic signed [15:0] direct_level;

    // An entry matches on either the upper 32 bits or the lower 16 bits.
    assign hit = (item.device_address[47:16] == beacon_address[47:16]) ||
                 (item.device_address[15:0]  == beacon_address[15:0]);

    assign age   = item.now_ms - seen_reg;
    assign stale = age > {16'h0000, stale_timeout_ms};

    assign direct       = level_reg <= LEVEL_DIRECT_MAX;
    assign direct_level = {item.signal_dbm, 8'h00};
    assign rssi_ext     = {{16{item.signal_dbm[7]}}, item.signal_dbm};
    assign level_ext    = {{8{level_reg[15]}}, level_reg};
    assign blend_sum    = rssi_ext * WEIGHT_NEW_Q88 + level_ext * WEIGHT_OLD;
    assign blend_round  = brt_round256(blend_sum);

    always_comb
    begin
        level_next = level_reg;
        seen_next  = seen_reg;
        if (item.kind == KIND_SWEEP)
        begin
            if (stale)
            begin
                level_next = LEVEL_RESET;
            end
        end
        else if (hit)
        begin
            seen_next  = item.now_ms;
            // The blended value always lies between its two inputs, so it fits.
            level_next = direct ? direct_level : blend_round[15:0];
        end
    end

    assign matched = (item.kind == KIND_ADVERT) && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LEVEL_RESET;
            seen_reg  <= '0;
        end
        else if (update)
        begin
            level_reg <= level_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

// ===== rtl/brt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brt_checker: port-level assertions for the beacon RSSI tracker
// Watches the handshakes and checks holding, back-pressure and latency.
// ----------------------------------------------------------------------------
module brt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [7:0]             level_0,
    input logic signed [7:0]             level_1,
    input logic signed [7:0]             level_2,
    input logic [2:0]                    match_mask
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(level_0) && $stable(level_1) &&
                                    $stable(level_2) && $stable(match_mask))
        else $error("stalled result changed");

    // Input back-pressure only arises from a stalled result.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // Every input transfer leads to an offered result through the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("no result two cycles after input transfer");

endmodule

bind beacon_rssi_tracker brt_checker u_brt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .level_0    (level_0),
    .level_1    (level_1),
    .level_2    (level_2),
    .match_mask (match_mask)
);
